@@ rtl/dsc_pkg.sv @@
// Shared types, constants and helper functions of the datagram checksum receiver.
package dsc_pkg;

  // Header layout of a datagram.
  localparam int TERM_POS   = 0;
  localparam int SUM_FIRST  = 1;
  localparam int PNUM_FIRST = 5;
  localparam int HDR_BYTES  = 9;

  // Result field widths.
  localparam int KIND_W  = 2;
  localparam int REPLY_W = 6;
  localparam int PNUM_W  = 32;
  localparam int COUNT_W = 9;

  // Data byte counter saturates here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    RESP_ACK     = 2'd0,
    RESP_NAK_SEQ = 2'd1,
    RESP_NAK_SUM = 2'd2,
    RESP_END     = 2'd3
  } resp_kind_t;

  // One input beat: a datagram byte and its end flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  // One reply to a finished datagram.
  typedef struct packed {
    resp_kind_t          response_kind;
    logic [REPLY_W-1:0]  reply_sequence;
    logic [PNUM_W-1:0]   accepted_packet_number;
    logic [COUNT_W-1:0]  payload_length;
  } response_t;

  // Datagram fields as they stand once the current byte is taken in.
  typedef struct packed {
    logic               terminator;
    logic [31:0]        received_sum;
    logic [31:0]        running_sum;
    logic [PNUM_W-1:0]  header_pnum;
    logic [COUNT_W-1:0] data_count;
  } dgram_view_t;

  // Residues of 2^i modulo m for the 32 bit places of the packet number.
  function automatic logic [31:0][7:0] seq_weights(input int m);
    logic [31:0][7:0] w;
    int x;
    x = 1;
    for (int i = 0; i < 32; i++) begin
      w[i] = 8'(x);
      x = 2 * x;
      if (x >= m) begin
        x = x - m;
      end
    end
    return w;
  endfunction

endpackage

@@ rtl/dsc_stream_if.sv @@
// Valid/ready stream channel carrying one payload word per beat.
interface dsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/dsc_field_accum.sv @@
// Per-datagram header capture, data sum, length count and sequence residue.
module dsc_field_accum
  import dsc_pkg::*;
#(
  parameter int SEGMENT_BYTES = 512,
  parameter int DATA_BYTES    = 503,
  parameter int SEQ_MODULUS   = 64,
  localparam int SeqW         = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  byte_beat_t        beat,
  output dgram_view_t       view,
  output logic [SeqW-1:0]   residue
);

  localparam int PosW    = $clog2(SEGMENT_BYTES + 1);
  localparam int DataEnd = HDR_BYTES + DATA_BYTES;
  localparam int DataMax = (DataEnd < SEGMENT_BYTES) ? DataEnd : SEGMENT_BYTES;
  localparam int SumW    = SeqW + 3;

  localparam logic [PosW-1:0] SegLim  = PosW'(SEGMENT_BYTES);
  localparam logic [PosW-1:0] HdrPos  = PosW'(HDR_BYTES);
  localparam logic [PosW-1:0] DataLim = PosW'(DataMax);
  localparam logic [PosW-1:0] PnumPos = PosW'(PNUM_FIRST);
  localparam logic [SeqW:0]   ModW    = (SeqW + 1)'(SEQ_MODULUS);
  localparam logic [SumW-1:0] Mod1    = SumW'(SEQ_MODULUS);
  localparam logic [SumW-1:0] Mod2    = SumW'(2 * SEQ_MODULUS);
  localparam logic [SumW-1:0] Mod4    = SumW'(4 * SEQ_MODULUS);
  localparam logic [31:0][7:0] Weights = seq_weights(SEQ_MODULUS);

  logic [PosW-1:0]    pos, pos_next;
  logic               term, term_next;
  logic [31:0]        rsum, rsum_next;
  logic [31:0]        pnum, pnum_next;
  logic [SeqW-1:0]    res, res_next;
  logic [31:0]        sum, sum_next;
  logic               stopped, stopped_next;
  logic [COUNT_W-1:0] count, count_next;

  logic               active;
  logic               in_data;
  logic               in_pnum;
  logic [1:0]         lane;
  logic [SeqW-1:0]    term_res;
  logic [7:0][SumW-1:0] terms;
  logic [SumW-1:0]    pair_a, pair_b, pair_c, pair_d;
  logic [SumW-1:0]    quad_a, quad_b, byte_sum;
  logic [SumW-1:0]    red_4, red_2;

  assign active  = (pos < SegLim);
  assign in_data = (pos >= HdrPos) && (pos < DataLim);
  assign in_pnum = (pos >= PnumPos) && (pos < HdrPos);
  assign lane    = 2'(pos - PnumPos);

  // Residue of this byte's share of the packet number: the place weights of its
  // set bits are added in a tree and the total is brought below the modulus.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      terms[j] = beat.data_byte[j] ? SumW'(Weights[{lane, 3'(j)}][SeqW-1:0]) : '0;
    end
    pair_a   = terms[0] + terms[1];
    pair_b   = terms[2] + terms[3];
    pair_c   = terms[4] + terms[5];
    pair_d   = terms[6] + terms[7];
    quad_a   = pair_a + pair_b;
    quad_b   = pair_c + pair_d;
    byte_sum = quad_a + quad_b;
    red_4    = (byte_sum >= Mod4) ? byte_sum - Mod4 : byte_sum;
    red_2    = (red_4 >= Mod2) ? red_4 - Mod2 : red_4;
    term_res = (red_2 >= Mod1) ? SeqW'(red_2 - Mod1) : red_2[SeqW-1:0];
  end

  // Next state of the datagram fields for the byte at hand.
  always_comb begin
    logic [SeqW:0] acc;
    acc          = {1'b0, res} + {1'b0, term_res};
    pos_next     = active ? pos + 1'b1 : pos;
    term_next    = term;
    rsum_next    = rsum;
    pnum_next    = pnum;
    res_next     = res;
    sum_next     = sum;
    stopped_next = stopped;
    count_next   = count;
    if (active) begin
      if (pos == PosW'(TERM_POS)) begin
        term_next = (beat.data_byte == 8'd0);
      end
      for (int k = 0; k < 4; k++) begin
        if (pos == PosW'(SUM_FIRST + k)) begin
          rsum_next[8*k +: 8] = beat.data_byte;
        end
        if (pos == PosW'(PNUM_FIRST + k)) begin
          pnum_next[8*k +: 8] = beat.data_byte;
        end
      end
      if (in_pnum) begin
        res_next = (acc >= ModW) ? SeqW'(acc - ModW) : acc[SeqW-1:0];
      end
      if (in_data && !stopped) begin
        if (beat.data_byte == 8'd0) begin
          stopped_next = 1'b1;
        end else begin
          sum_next = sum + {{24{beat.data_byte[7]}}, beat.data_byte};
          if (count != COUNT_MAX) begin
            count_next = count + 1'b1;
          end
        end
      end
    end
  end

  // Datagram state; a last byte clears it for the next datagram.
  always_ff @(posedge clk) begin
    if (rst || (step && beat.last_byte)) begin
      pos     <= '0;
      term    <= 1'b0;
      rsum    <= '0;
      pnum    <= '0;
      res     <= '0;
      sum     <= '0;
      stopped <= 1'b0;
      count   <= '0;
    end else if (step) begin
      pos     <= pos_next;
      term    <= term_next;
      rsum    <= rsum_next;
      pnum    <= pnum_next;
      res     <= res_next;
      sum     <= sum_next;
      stopped <= stopped_next;
      count   <= count_next;
    end
  end

  assign view.terminator   = term_next;
  assign view.received_sum = rsum_next;
  assign view.running_sum  = sum_next;
  assign view.header_pnum  = pnum_next;
  assign view.data_count   = count_next;
  assign residue           = res_next;

endmodule

@@ rtl/dsc_verdict.sv @@
// Sequence and checksum judgement, expected sequence register and reply register.
module dsc_verdict
  import dsc_pkg::*;
#(
  parameter int SEQ_MODULUS = 64,
  localparam int SeqW       = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                judge,
  input  dgram_view_t         view,
  input  logic [SeqW-1:0]     residue,
  output logic                out_free,
  dsc_stream_if.source        resp
);

  localparam logic [SeqW-1:0] SeqLast = SeqW'(SEQ_MODULUS - 1);

  logic [SeqW-1:0] expected, expected_next;
  logic [SeqW-1:0] expected_inc;
  logic            resp_valid;
  response_t       resp_data, resp_data_next;

  assign out_free     = !resp_valid || resp.ready;
  assign expected_inc = (expected == SeqLast) ? '0 : expected + 1'b1;

  // Judge the finished datagram: terminator, then sequence, then checksum.
  always_comb begin
    resp_data_next.accepted_packet_number = view.header_pnum;
    resp_data_next.payload_length         = view.data_count;
    resp_data_next.reply_sequence         = REPLY_W'(expected);
    expected_next                         = expected;
    priority if (view.terminator) begin
      resp_data_next.response_kind          = RESP_END;
      resp_data_next.reply_sequence         = '0;
      resp_data_next.accepted_packet_number = '0;
      resp_data_next.payload_length         = '0;
      expected_next                         = '0;
    end else if (residue != expected) begin
      resp_data_next.response_kind  = RESP_NAK_SEQ;
      resp_data_next.payload_length = '0;
    end else if (view.running_sum != view.received_sum) begin
      resp_data_next.response_kind = RESP_NAK_SUM;
    end else begin
      resp_data_next.response_kind  = RESP_ACK;
      resp_data_next.reply_sequence = REPLY_W'(expected_inc);
      expected_next                 = expected_inc;
    end
  end

  // Expected sequence and reply valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected   <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (judge) begin
        expected <= expected_next;
      end
      if (out_free) begin
        resp_valid <= judge;
      end
    end
  end

  // Reply payload register.
  always_ff @(posedge clk) begin
    if (judge) begin
      resp_data <= resp_data_next;
    end
  end

  assign resp.valid   = resp_valid;
  assign resp.payload = resp_data;

endmodule

@@ rtl/datagram_seq_checksum_receiver_unit.sv @@
// Top level of the datagram receiver: input beat register, field accumulator and verdict.
//
//  Channel | Modport | Payload      | Beat
//  rx      | sink    | byte_beat_t  | one datagram byte, last_byte on the final one
//  resp    | source  | response_t   | one reply per datagram
//
// A byte is taken every cycle unless a last byte waits on a full reply register; it sits
// in the input register, and a last byte's reply is held in the reply register on resp.
// The header, sum and residue are updated combinationally for each byte as it moves on.
// Synchronous reset clears the expected sequence, all datagram state and both valids.
// A stalled reply holds only last bytes back; other bytes keep flowing into the
// accumulator while the reply waits.
module datagram_seq_checksum_receiver_unit
  import dsc_pkg::*;
#(
  parameter int SEGMENT_BYTES = 512,
  parameter int DATA_BYTES    = 503,
  parameter int SEQ_MODULUS   = 64
) (
  input  logic         clk,
  input  logic         rst,
  dsc_stream_if.sink   rx,
  dsc_stream_if.source resp
);

  localparam int SeqW = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1;

  logic            in_valid;
  byte_beat_t      in_beat;
  logic            advance;
  logic            judge;
  logic            out_free;
  dgram_view_t     view;
  logic [SeqW-1:0] residue;

  // The held byte moves on unless it is a last byte facing a full reply register.
  assign advance  = in_valid && (!in_beat.last_byte || out_free);
  assign judge    = advance && in_beat.last_byte;
  assign rx.ready = !in_valid || advance;

  // Input beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready) begin
      in_beat <= rx.payload;
    end
  end

  dsc_field_accum #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .DATA_BYTES    (DATA_BYTES),
    .SEQ_MODULUS   (SEQ_MODULUS)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .beat    (in_beat),
    .view    (view),
    .residue (residue)
  );

  dsc_verdict #(
    .SEQ_MODULUS (SEQ_MODULUS)
  ) u_verdict (
    .clk      (clk),
    .rst      (rst),
    .judge    (judge),
    .view     (view),
    .residue  (residue),
    .out_free (out_free),
    .resp     (resp)
  );

  // A reply appears only after a last byte was judged.
  a_reply_from_judge: assert property (@(posedge clk) disable iff (rst)
    $rose(resp.valid) |-> $past(judge))
    else $error("reply raised without a judged last byte");

  // A judged datagram always leaves a reply in the output register.
  a_judge_gives_reply: assert property (@(posedge clk) disable iff (rst)
    judge |=> resp.valid)
    else $error("judged datagram produced no reply");

  // A held byte that cannot move stays in the input register unchanged.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_beat))
    else $error("held input beat lost or changed");

endmodule
